@@ src/imhq_pkg.sv @@
// Shared codes and field widths of the indexed max-heap queue.
package imhq_pkg;

   localparam int ID_BITS       = 10;
   localparam int SLOT_BITS     = 11;
   localparam int PORT_KEY_BITS = 32;

   typedef logic [1:0] action_type;
   typedef logic [1:0] err_type;

   localparam action_type ACT_INSERT  = 2'd0;
   localparam action_type ACT_EXTRACT = 2'd1;
   localparam action_type ACT_SET_KEY = 2'd2;
   localparam action_type ACT_READ    = 2'd3;

   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_EMPTY = 2'd2;
   localparam err_type ERR_SLOT  = 2'd3;

endpackage

@@ src/indexed_max_heap_queue.sv @@
// Indexed binary max-heap priority queue with a one-write, one-read heap memory and a sift sequencer.
//
// The block holds up to CAPACITY (key, item id) pairs in a one-based binary max-heap kept in
// one on-chip memory with one write port and one registered read port. One request transfer
// is taken at a time, and req_stall stays high until its work is finished. A read fetches
// its slot and reports it; a bad request goes straight to the result. An insert walks every
// level from its slot up to the root, with a parent read and then a compare and a write per
// level; a set key first reads its slot and then walks the same way. An extract walks down
// from the root with a left child read, a right child read and a compare and write per
// level, until no swap is made.
// Every walk shares the one memory read port. The result waits in an output register, so
// the next request can be taken while an earlier result is still held by rsp_stall. Slot 1
// is mirrored in a register so the top key and top id are reported without a memory read.
// No clearing pass runs after reset; heap slots are written before they are ever read.
module indexed_max_heap_queue #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  imhq_pkg::action_type                   req_action,
   input  logic [imhq_pkg::PORT_KEY_BITS-1:0]     req_key,
   input  logic [imhq_pkg::ID_BITS-1:0]           req_item_id,
   input  logic [imhq_pkg::SLOT_BITS-1:0]         req_slot,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [imhq_pkg::PORT_KEY_BITS-1:0]     rsp_entry_key,
   output logic [imhq_pkg::ID_BITS-1:0]           rsp_entry_id,
   output logic [imhq_pkg::PORT_KEY_BITS-1:0]     rsp_top_key,
   output logic [imhq_pkg::ID_BITS-1:0]           rsp_top_id,
   output logic [imhq_pkg::SLOT_BITS-1:0]         rsp_count,
   output logic                                   rsp_empty_res,
   output imhq_pkg::err_type                      rsp_error
);

   localparam int IDB = imhq_pkg::ID_BITS;
   localparam int EW  = KEY_BITS + IDB;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int AW  = $clog2(CAPACITY);
   localparam int XW  = (CW > imhq_pkg::SLOT_BITS) ? CW : imhq_pkg::SLOT_BITS;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_UP_RD  = 4'd1;
   localparam logic [3:0] ST_UP_CMP = 4'd2;
   localparam logic [3:0] ST_SK_LD  = 4'd3;
   localparam logic [3:0] ST_RD_LD  = 4'd4;
   localparam logic [3:0] ST_EX_LD  = 4'd5;
   localparam logic [3:0] ST_SD_L   = 4'd6;
   localparam logic [3:0] ST_SD_R   = 4'd7;
   localparam logic [3:0] ST_SD_D   = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   // Heap storage: slot n lives at address n - 1, key in the upper bits, id in the lower.
   logic [EW-1:0] heap_mem [CAPACITY];
   logic [EW-1:0] rd_data_ff;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [KEY_BITS-1:0] cur_key_ff, cur_key_in;
   logic [IDB-1:0]      cur_id_ff, cur_id_in;
   logic [KEY_BITS-1:0] lft_key_ff, lft_key_in;
   logic [IDB-1:0]      lft_id_ff, lft_id_in;
   logic [KEY_BITS-1:0] ek_ff, ek_in;
   logic [IDB-1:0]      eid_ff, eid_in;
   imhq_pkg::err_type   err_ff, err_in;
   logic [KEY_BITS-1:0] top_key_ff;
   logic [IDB-1:0]      top_id_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [imhq_pkg::PORT_KEY_BITS-1:0]  rsp_entry_key_ff, rsp_entry_key_in;
   logic [IDB-1:0]                      rsp_entry_id_ff, rsp_entry_id_in;
   logic [imhq_pkg::PORT_KEY_BITS-1:0]  rsp_top_key_ff, rsp_top_key_in;
   logic [IDB-1:0]                      rsp_top_id_ff, rsp_top_id_in;
   logic [imhq_pkg::SLOT_BITS-1:0]      rsp_count_ff, rsp_count_in;
   logic                                rsp_empty_ff, rsp_empty_in;
   imhq_pkg::err_type                   rsp_error_ff, rsp_error_in;

   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [KEY_BITS-1:0] wr_key;
   logic [IDB-1:0]      wr_id;

   logic [KEY_BITS-1:0] key_in;
   logic [KEY_BITS-1:0] rd_key;
   logic [IDB-1:0]      rd_id;
   logic [CW:0]         lchild, rchild;
   logic                l_ok, r_ok;
   logic                slot_bad;
   logic                accept;

   assign key_in   = KEY_BITS'(req_key);
   assign rd_key   = rd_data_ff[EW-1:IDB];
   assign rd_id    = rd_data_ff[IDB-1:0];
   assign lchild   = {pos_ff, 1'b0};
   assign rchild   = {pos_ff, 1'b1};
   assign l_ok     = lchild <= {1'b0, cnt_ff};
   assign r_ok     = rchild <= {1'b0, cnt_ff};
   assign slot_bad = (req_slot == '0) || (XW'(req_slot) > XW'(cnt_ff));
   assign accept   = req_valid && !req_stall;

   // New requests are taken only while the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      cur_key_in = cur_key_ff;
      cur_id_in  = cur_id_ff;
      lft_key_in = lft_key_ff;
      lft_id_in  = lft_id_ff;
      ek_in      = ek_ff;
      eid_in     = eid_ff;
      err_in     = err_ff;
      rd_en      = 1'b0;
      rd_addr    = AW'(pos_ff - 1'b1);
      wr_en      = 1'b0;
      wr_addr    = AW'(pos_ff - 1'b1);
      wr_key     = cur_key_ff;
      wr_id      = cur_id_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_entry_key_in = rsp_entry_key_ff;
      rsp_entry_id_in  = rsp_entry_id_ff;
      rsp_top_key_in   = rsp_top_key_ff;
      rsp_top_id_in    = rsp_top_id_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_error_in     = rsp_error_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ek_in  = '0;
               eid_in = '0;
               err_in = imhq_pkg::ERR_NONE;
               case (req_action)
                  imhq_pkg::ACT_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        err_in   = imhq_pkg::ERR_FULL;
                        state_in = ST_DONE;
                     end else begin
                        cnt_in     = cnt_ff + 1'b1;
                        pos_in     = cnt_ff + 1'b1;
                        cur_key_in = key_in;
                        cur_id_in  = req_item_id;
                        state_in   = ST_UP_RD;
                     end
                  end
                  imhq_pkg::ACT_EXTRACT: begin
                     if (cnt_ff == '0) begin
                        err_in   = imhq_pkg::ERR_EMPTY;
                        state_in = ST_DONE;
                     end else begin
                        ek_in  = top_key_ff;
                        eid_in = top_id_ff;
                        cnt_in = cnt_ff - 1'b1;
                        pos_in = CW'(1);
                        if (cnt_ff == CW'(1)) begin
                           state_in = ST_DONE;
                        end else begin
                           // The last entry moves to the root before sifting down.
                           rd_en    = 1'b1;
                           rd_addr  = AW'(cnt_ff - 1'b1);
                           state_in = ST_EX_LD;
                        end
                     end
                  end
                  default: begin
                     if (slot_bad) begin
                        err_in   = imhq_pkg::ERR_SLOT;
                        state_in = ST_DONE;
                     end else begin
                        pos_in     = CW'(req_slot);
                        cur_key_in = key_in;
                        rd_en      = 1'b1;
                        rd_addr    = AW'(req_slot - 1'b1);
                        if (req_action == imhq_pkg::ACT_SET_KEY) begin
                           state_in = ST_SK_LD;
                        end else begin
                           state_in = ST_RD_LD;
                        end
                     end
                  end
               endcase
            end
         end
         ST_SK_LD: begin
            cur_id_in = rd_id;
            ek_in     = cur_key_ff;
            eid_in    = rd_id;
            state_in  = ST_UP_RD;
         end
         ST_RD_LD: begin
            ek_in    = rd_key;
            eid_in   = rd_id;
            state_in = ST_DONE;
         end
         ST_UP_RD: begin
            if (pos_ff == CW'(1)) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'((pos_ff >> 1) - 1'b1);
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // The walk always reaches the root; the larger of the pair moves on upward.
            wr_en = 1'b1;
            if (cur_key_ff > rd_key) begin
               wr_key = rd_key;
               wr_id  = rd_id;
            end else begin
               cur_key_in = rd_key;
               cur_id_in  = rd_id;
            end
            pos_in   = pos_ff >> 1;
            state_in = ST_UP_RD;
         end
         ST_EX_LD: begin
            cur_key_in = rd_key;
            cur_id_in  = rd_id;
            state_in   = ST_SD_L;
         end
         ST_SD_L: begin
            if (!l_ok) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(lchild - 1'b1);
               state_in = ST_SD_R;
            end
         end
         ST_SD_R: begin
            lft_key_in = rd_key;
            lft_id_in  = rd_id;
            if (r_ok) begin
               rd_en   = 1'b1;
               rd_addr = AW'(rchild - 1'b1);
            end
            state_in = ST_SD_D;
         end
         ST_SD_D: begin
            wr_en    = 1'b1;
            state_in = ST_SD_L;
            if (r_ok && (rd_key > cur_key_ff) && (rd_key > lft_key_ff)) begin
               wr_key = rd_key;
               wr_id  = rd_id;
               pos_in = CW'(rchild);
            end else if (lft_key_ff > cur_key_ff) begin
               wr_key = lft_key_ff;
               wr_id  = lft_id_ff;
               pos_in = CW'(lchild);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_entry_key_in = imhq_pkg::PORT_KEY_BITS'(ek_ff);
               rsp_entry_id_in  = eid_ff;
               rsp_top_key_in   = (cnt_ff == '0) ? '0
                                                 : imhq_pkg::PORT_KEY_BITS'(top_key_ff);
               rsp_top_id_in    = (cnt_ff == '0) ? '0 : top_id_ff;
               rsp_count_in     = imhq_pkg::SLOT_BITS'(cnt_ff);
               rsp_empty_in     = (cnt_ff == '0);
               rsp_error_in     = err_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= {wr_key, wr_id};
      end
      if (rd_en) begin
         rd_data_ff <= heap_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      cur_key_ff       <= cur_key_in;
      cur_id_ff        <= cur_id_in;
      lft_key_ff       <= lft_key_in;
      lft_id_ff        <= lft_id_in;
      ek_ff            <= ek_in;
      eid_ff           <= eid_in;
      err_ff           <= err_in;
      rsp_entry_key_ff <= rsp_entry_key_in;
      rsp_entry_id_ff  <= rsp_entry_id_in;
      rsp_top_key_ff   <= rsp_top_key_in;
      rsp_top_id_ff    <= rsp_top_id_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_error_ff     <= rsp_error_in;
      // The root is mirrored here on every write to slot 1.
      if (wr_en && (wr_addr == '0)) begin
         top_key_ff <= wr_key;
         top_id_ff  <= wr_id;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_entry_key = rsp_entry_key_ff;
   assign rsp_entry_id  = rsp_entry_id_ff;
   assign rsp_top_key   = rsp_top_key_ff;
   assign rsp_top_id    = rsp_top_id_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_error     = rsp_error_ff;

endmodule

@@ src/imhq_checker.sv @@
// Port-level assertions for the indexed max-heap queue and their bind.
module imhq_port_props (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [imhq_pkg::PORT_KEY_BITS-1:0] rsp_top_key,
   input logic [imhq_pkg::ID_BITS-1:0]       rsp_top_id,
   input logic [imhq_pkg::SLOT_BITS-1:0]     rsp_count,
   input logic                               rsp_empty_res,
   input imhq_pkg::err_type                  rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_error) && $stable(rsp_count))
      else $error("result changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_top_key == '0) && (rsp_top_id == '0))
      else $error("empty heap reports a top entry");

   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == imhq_pkg::ERR_EMPTY) |-> rsp_empty_res)
      else $error("empty error on a heap that is not empty");

endmodule

bind indexed_max_heap_queue imhq_port_props u_imhq_port_props (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_top_key   (rsp_top_key),
   .rsp_top_id    (rsp_top_id),
   .rsp_count     (rsp_count),
   .rsp_empty_res (rsp_empty_res),
   .rsp_error     (rsp_error)
);
